[design/vna_pkg.sv]
// Shared types, constants and helper functions for the vertex normal accumulator.
package vna_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int AW      = $clog2(VERTEX_COUNT);
    localparam int IDX_W   = 10;
    localparam int COORD_W = 32;
    localparam int NORM_W  = 16;
    localparam int SUM_W   = 24;
    localparam int EDGE_W  = 33;
    localparam int MAG_W   = 62;
    localparam int CR_W    = 63;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int Q_W     = 15;
    localparam int REM_W   = 46;
    localparam int CNT_W   = 5;

    localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TRI   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_A  = 2'd0,
        SEL_B  = 2'd1,
        SEL_C  = 2'd2,
        SEL_VI = 2'd3
    } t_vsel;

    typedef enum logic {
        MM_CROSS  = 1'b0,
        MM_SQUARE = 1'b1
    } t_mmode;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_FETCH, S_FETCH_LAST, S_EDGE, S_ESCALE,
        S_CROSS, S_QRD, S_VLOAD, S_NORM, S_SQUARE, S_SQRT, S_DIV_INIT,
        S_DIVIDE, S_SUM_RD, S_SUM_WR, S_RESULT
    } t_state;

    typedef struct packed {
        logic       in_load;
        logic       pos_we;
        t_vsel      pos_sel;
        logic       pos_shift;
        logic       edge_load;
        logic       escale_step;
        logic       acc_clr;
        logic       mul_go;
        t_mmode     mul_mode;
        logic [2:0] idx;
        logic       vload;
        logic       norm_step;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        t_vsel      sum_sel;
        logic       sum_we;
        logic       clear;
        logic       res_load;
        t_status    res_status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic tri_ok;
        logic vi_ok;
        logic clr_last;
        logic e_big;
        logic v_zero;
        logic v_norm;
    } t_stat;

    typedef struct packed {
        logic [2:0] ia;
        logic [2:0] ib;
        logic [1:0] tgt;
        logic       sub;
    } t_mpair;

    function automatic logic idx_ok(logic [IDX_W-1:0] idx);
        return 32'(idx) < VERTEX_COUNT;
    endfunction

    function automatic t_mpair mul_pair(logic [2:0] k);
        t_mpair p;
        case (k)
            3'd0:    p = '{ia: 3'd1, ib: 3'd5, tgt: 2'd0, sub: 1'b0};
            3'd1:    p = '{ia: 3'd2, ib: 3'd4, tgt: 2'd0, sub: 1'b1};
            3'd2:    p = '{ia: 3'd2, ib: 3'd3, tgt: 2'd1, sub: 1'b0};
            3'd3:    p = '{ia: 3'd0, ib: 3'd5, tgt: 2'd1, sub: 1'b1};
            3'd4:    p = '{ia: 3'd0, ib: 3'd4, tgt: 2'd2, sub: 1'b0};
            default: p = '{ia: 3'd1, ib: 3'd3, tgt: 2'd2, sub: 1'b1};
        endcase
        return p;
    endfunction

endpackage

[design/vertex_normal_accumulator_core.sv]
// A load stores the vertex position; a query normalizes the stored sum into its result,
// or reports a zero status without square root and divide when the sum is zero.
// Add-triangle time is set by the 32-step square root, the 15-step divider lanes
// and the data-dependent scaling shifts; a degenerate one ends before the root.
// One beat is processed at a time; a finished result waits in the output register.
// After reset every entry of the sum store is cleared before input is taken.
module vertex_normal_accumulator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic [vna_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_a,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_b,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_c,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [vna_pkg::IDX_W-1:0]          o_queried_vertex,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_z,
    output logic [1:0]                         o_status
);

    vna_pkg::t_cmd  cmd;
    vna_pkg::t_stat stat;

    vna_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    vna_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_vertex_index   (i_vertex_index),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_corner_a       (i_corner_a),
        .i_corner_b       (i_corner_b),
        .i_corner_c       (i_corner_c),
        .o_queried_vertex (o_queried_vertex),
        .o_normal_x       (o_normal_x),
        .o_normal_y       (o_normal_y),
        .o_normal_z       (o_normal_z),
        .o_status         (o_status)
    );

endmodule

[design/vna_ctrl.sv]
// Controller state machine sequencing loads, triangle accumulation and queries.
module vna_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  vna_pkg::t_stat i_stat,
    output vna_pkg::t_cmd  o_cmd
);

    vna_pkg::t_state  r_state, n_state;
    logic [vna_pkg::CNT_W-1:0] r_cnt, n_cnt;
    vna_pkg::t_status r_res_st, n_res_st;
    logic             r_ov;
    logic             res_go;

    assign res_go = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vna_pkg::S_CLEAR;
            r_cnt    <= '0;
            r_res_st <= vna_pkg::ST_OK;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_res_st <= n_res_st;
            if (o_cmd.res_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_res_st = r_res_st;
        unique case (r_state)
            vna_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = vna_pkg::S_IDLE;
            end
            vna_pkg::S_IDLE: begin
                if (i_in_valid) n_state = vna_pkg::S_DECODE;
            end
            vna_pkg::S_DECODE: begin
                n_cnt = '0;
                unique case (i_stat.op)
                    vna_pkg::OP_LOAD: n_state = vna_pkg::S_IDLE;
                    vna_pkg::OP_TRI: begin
                        n_state = i_stat.tri_ok ? vna_pkg::S_FETCH : vna_pkg::S_IDLE;
                    end
                    vna_pkg::OP_QUERY: begin
                        if (i_stat.vi_ok) begin
                            n_state  = vna_pkg::S_QRD;
                            n_res_st = vna_pkg::ST_OK;
                        end else begin
                            n_state  = vna_pkg::S_RESULT;
                            n_res_st = vna_pkg::ST_RANGE;
                        end
                    end
                    default: n_state = vna_pkg::S_IDLE;
                endcase
            end
            vna_pkg::S_FETCH: begin
                if (r_cnt == 5'd2) begin
                    n_state = vna_pkg::S_FETCH_LAST;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            vna_pkg::S_FETCH_LAST: n_state = vna_pkg::S_EDGE;
            vna_pkg::S_EDGE:       n_state = vna_pkg::S_ESCALE;
            vna_pkg::S_ESCALE: begin
                n_cnt = '0;
                if (!i_stat.e_big) n_state = vna_pkg::S_CROSS;
            end
            vna_pkg::S_CROSS: begin
                if (r_cnt == 5'd6) begin
                    n_state = vna_pkg::S_VLOAD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            vna_pkg::S_QRD:   n_state = vna_pkg::S_VLOAD;
            vna_pkg::S_VLOAD: n_state = vna_pkg::S_NORM;
            vna_pkg::S_NORM: begin
                n_cnt = '0;
                if (i_stat.v_zero) begin
                    if (i_stat.op == vna_pkg::OP_QUERY) begin
                        n_state  = vna_pkg::S_RESULT;
                        n_res_st = vna_pkg::ST_ZERO;
                    end else begin
                        n_state = vna_pkg::S_IDLE;
                    end
                end else if (i_stat.v_norm) begin
                    n_state = vna_pkg::S_SQUARE;
                end
            end
            vna_pkg::S_SQUARE: begin
                if (r_cnt == 5'd3) begin
                    n_state = vna_pkg::S_SQRT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            vna_pkg::S_SQRT: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_state = vna_pkg::S_DIV_INIT;
            end
            vna_pkg::S_DIV_INIT: begin
                n_state = vna_pkg::S_DIVIDE;
                n_cnt   = '0;
            end
            vna_pkg::S_DIVIDE: begin
                if (r_cnt == 5'd14) begin
                    n_cnt   = '0;
                    n_state = (i_stat.op == vna_pkg::OP_QUERY) ? vna_pkg::S_RESULT
                                                               : vna_pkg::S_SUM_RD;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            vna_pkg::S_SUM_RD: n_state = vna_pkg::S_SUM_WR;
            vna_pkg::S_SUM_WR: begin
                if (r_cnt == 5'd2) begin
                    n_state = vna_pkg::S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_state = vna_pkg::S_SUM_RD;
                    n_cnt   = r_cnt + 5'd1;
                end
            end
            vna_pkg::S_RESULT: begin
                if (res_go) n_state = vna_pkg::S_IDLE;
            end
            default: n_state = vna_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_cnt[2:0];
        o_in_ready = 1'b0;
        unique case (r_state)
            vna_pkg::S_CLEAR: o_cmd.clear = 1'b1;
            vna_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_load = i_in_valid;
            end
            vna_pkg::S_DECODE: o_cmd.pos_we = (i_stat.op == vna_pkg::OP_LOAD);
            vna_pkg::S_FETCH: begin
                o_cmd.pos_sel   = vna_pkg::t_vsel'(r_cnt[1:0]);
                o_cmd.pos_shift = (r_cnt != 5'd0);
            end
            vna_pkg::S_FETCH_LAST: o_cmd.pos_shift = 1'b1;
            vna_pkg::S_EDGE: begin
                o_cmd.edge_load = 1'b1;
                o_cmd.acc_clr   = 1'b1;
            end
            vna_pkg::S_ESCALE: o_cmd.escale_step = i_stat.e_big;
            vna_pkg::S_CROSS: begin
                o_cmd.mul_go   = (r_cnt < 5'd6);
                o_cmd.mul_mode = vna_pkg::MM_CROSS;
            end
            vna_pkg::S_QRD:   o_cmd.sum_sel = vna_pkg::SEL_VI;
            vna_pkg::S_VLOAD: o_cmd.vload = 1'b1;
            vna_pkg::S_NORM: begin
                o_cmd.acc_clr   = 1'b1;
                o_cmd.norm_step = !i_stat.v_zero && !i_stat.v_norm;
            end
            vna_pkg::S_SQUARE: begin
                o_cmd.mul_go   = (r_cnt < 5'd3);
                o_cmd.mul_mode = vna_pkg::MM_SQUARE;
            end
            vna_pkg::S_SQRT:     o_cmd.sqrt_step = 1'b1;
            vna_pkg::S_DIV_INIT: o_cmd.div_init = 1'b1;
            vna_pkg::S_DIVIDE:   o_cmd.div_step = 1'b1;
            vna_pkg::S_SUM_RD:   o_cmd.sum_sel = vna_pkg::t_vsel'(r_cnt[1:0]);
            vna_pkg::S_SUM_WR: begin
                o_cmd.sum_sel = vna_pkg::t_vsel'(r_cnt[1:0]);
                o_cmd.sum_we  = 1'b1;
            end
            vna_pkg::S_RESULT: begin
                o_cmd.res_load   = res_go;
                o_cmd.res_status = r_res_st;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_out_valid = r_ov;

endmodule

[design/vna_dp.sv]
// Datapath: vertex and sum stores, shared multiplier, normalizer, square root and dividers.
module vna_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vna_pkg::t_cmd                      i_cmd,
    output vna_pkg::t_stat                     o_stat,
    input  logic [1:0]                         i_operation,
    input  logic [vna_pkg::IDX_W-1:0]          i_vertex_index,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] i_coord_z,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_a,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_b,
    input  logic [vna_pkg::IDX_W-1:0]          i_corner_c,
    output logic [vna_pkg::IDX_W-1:0]          o_queried_vertex,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_x,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_y,
    output logic signed [vna_pkg::NORM_W-1:0]  o_normal_z,
    output logic [1:0]                         o_status
);

    localparam int PW = 3 * vna_pkg::COORD_W;
    localparam int SW = 3 * vna_pkg::SUM_W;

    logic [1:0]                        r_op;
    logic [vna_pkg::IDX_W-1:0]         r_vi, r_ca, r_cb, r_cc;
    logic [PW-1:0]                     r_cxyz;
    logic [PW-1:0]                     pos_mem [vna_pkg::VERTEX_COUNT];
    logic [PW-1:0]                     r_pos_rd;
    logic [PW-1:0]                     r_p [3];
    logic [SW-1:0]                     sum_mem [vna_pkg::VERTEX_COUNT];
    logic [SW-1:0]                     r_sum_rd;
    logic [SW-1:0]                     sum_wdata;
    logic [vna_pkg::AW-1:0]            r_clr;
    logic [vna_pkg::AW-1:0]            pos_addr, sum_addr;
    logic [vna_pkg::EDGE_W-1:0]        r_em [6];
    logic                              r_en [6];
    logic [vna_pkg::EDGE_W-1:0]        d_mag [6];
    logic                              d_neg [6];
    logic signed [30:0]                mul_a, mul_b;
    logic signed [61:0]                r_prod;
    logic [2:0]                        r_pk;
    vna_pkg::t_mmode                   r_pmode;
    logic                              r_pv;
    logic signed [vna_pkg::CR_W-1:0]   r_cr [3];
    logic [vna_pkg::MAG_W-1:0]         r_vm [3];
    logic                              r_vn [3];
    logic [vna_pkg::MAG_W-1:0]         orv;
    logic [vna_pkg::SQ_W-1:0]          r_x, r_r, r_bit, sq_t;
    logic [vna_pkg::LEN_W-1:0]         len;
    logic [vna_pkg::REM_W-1:0]         r_rem [3];
    logic [vna_pkg::REM_W-1:0]         r_dvs;
    logic [vna_pkg::Q_W-1:0]           r_q [3];
    logic signed [vna_pkg::NORM_W-1:0] nrm [3];
    logic [vna_pkg::EDGE_W-1:0]        eor;

    function automatic logic signed [30:0] sval(logic [vna_pkg::EDGE_W-1:0] m, logic n);
        logic signed [30:0] v;
        v = $signed({1'b0, m[29:0]});
        return n ? -v : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_op   <= i_operation;
            r_vi   <= i_vertex_index;
            r_ca   <= i_corner_a;
            r_cb   <= i_corner_b;
            r_cc   <= i_corner_c;
            r_cxyz <= {i_coord_x, i_coord_y, i_coord_z};
        end
    end

    always_comb begin
        unique case (i_cmd.pos_sel)
            vna_pkg::SEL_A: pos_addr = vna_pkg::AW'(r_ca);
            vna_pkg::SEL_B: pos_addr = vna_pkg::AW'(r_cb);
            vna_pkg::SEL_C: pos_addr = vna_pkg::AW'(r_cc);
            default:        pos_addr = vna_pkg::AW'(r_vi);
        endcase
        unique case (i_cmd.sum_sel)
            vna_pkg::SEL_A: sum_addr = vna_pkg::AW'(r_ca);
            vna_pkg::SEL_B: sum_addr = vna_pkg::AW'(r_cb);
            vna_pkg::SEL_C: sum_addr = vna_pkg::AW'(r_cc);
            default:        sum_addr = vna_pkg::AW'(r_vi);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_we && vna_pkg::idx_ok(r_vi)) begin
            pos_mem[vna_pkg::AW'(r_vi)] <= r_cxyz;
        end
        r_pos_rd <= pos_mem[pos_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            sum_mem[r_clr] <= '0;
        end else if (i_cmd.sum_we) begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        r_sum_rd <= sum_mem[sum_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_shift) begin
            r_p[0] <= r_p[1];
            r_p[1] <= r_p[2];
            r_p[2] <= r_pos_rd;
        end
    end

    always_comb begin
        logic signed [vna_pkg::EDGE_W-1:0] d;
        for (int k = 0; k < 3; k++) begin
            d = vna_pkg::EDGE_W'($signed(r_p[1][(2-k)*32 +: 32]))
              - vna_pkg::EDGE_W'($signed(r_p[0][(2-k)*32 +: 32]));
            d_neg[k] = d[vna_pkg::EDGE_W-1];
            d_mag[k] = d_neg[k] ? vna_pkg::EDGE_W'(-d) : vna_pkg::EDGE_W'(d);
            d = vna_pkg::EDGE_W'($signed(r_p[2][(2-k)*32 +: 32]))
              - vna_pkg::EDGE_W'($signed(r_p[1][(2-k)*32 +: 32]));
            d_neg[k+3] = d[vna_pkg::EDGE_W-1];
            d_mag[k+3] = d_neg[k+3] ? vna_pkg::EDGE_W'(-d) : vna_pkg::EDGE_W'(d);
        end
        eor = '0;
        for (int k = 0; k < 6; k++) begin
            eor = eor | r_em[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            if (i_cmd.edge_load) begin
                r_em[k] <= d_mag[k];
                r_en[k] <= d_neg[k];
            end else if (i_cmd.escale_step) begin
                r_em[k] <= r_em[k] >> 1;
            end
        end
    end

    always_comb begin
        vna_pkg::t_mpair mp;
        mp = vna_pkg::mul_pair(i_cmd.idx);
        if (i_cmd.mul_mode == vna_pkg::MM_CROSS) begin
            mul_a = sval(r_em[mp.ia], r_en[mp.ia]);
            mul_b = sval(r_em[mp.ib], r_en[mp.ib]);
        end else begin
            mul_a = $signed({1'b0, r_vm[i_cmd.idx[1:0]][29:0]});
            mul_b = mul_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_go;
        end
        r_prod  <= mul_a * mul_b;
        r_pk    <= i_cmd.idx;
        r_pmode <= i_cmd.mul_mode;
    end

    assign sq_t = r_r + r_bit;
    assign len  = r_r[vna_pkg::LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        vna_pkg::t_mpair tp;
        tp = vna_pkg::mul_pair(r_pk);
        if (i_cmd.acc_clr) begin
            for (int i = 0; i < 3; i++) r_cr[i] <= '0;
            r_x   <= '0;
            r_r   <= '0;
            r_bit <= vna_pkg::SQ_W'(1) << 62;
        end else if (r_pv) begin
            if (r_pmode == vna_pkg::MM_CROSS) begin
                if (tp.sub) begin
                    r_cr[tp.tgt] <= r_cr[tp.tgt] - vna_pkg::CR_W'(r_prod);
                end else begin
                    r_cr[tp.tgt] <= r_cr[tp.tgt] + vna_pkg::CR_W'(r_prod);
                end
            end else begin
                r_x <= r_x + {2'b00, r_prod};
            end
        end else if (i_cmd.sqrt_step) begin
            if (r_x >= sq_t) begin
                r_x <= r_x - sq_t;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_comb begin
        orv = r_vm[0] | r_vm[1] | r_vm[2];
    end

    always_ff @(posedge i_clk) begin
        logic signed [vna_pkg::SUM_W-1:0] s;
        logic [vna_pkg::SUM_W:0]          sa;
        logic signed [vna_pkg::CR_W-1:0]  ca;
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.vload) begin
                if (r_op == vna_pkg::OP_QUERY) begin
                    s  = $signed(r_sum_rd[(2-i)*vna_pkg::SUM_W +: vna_pkg::SUM_W]);
                    sa = s[vna_pkg::SUM_W-1] ? -{s[vna_pkg::SUM_W-1], s}
                                             : {s[vna_pkg::SUM_W-1], s};
                    r_vn[i] <= s[vna_pkg::SUM_W-1];
                    r_vm[i] <= vna_pkg::MAG_W'(sa);
                end else begin
                    ca = r_cr[i][vna_pkg::CR_W-1] ? -r_cr[i] : r_cr[i];
                    r_vn[i] <= r_cr[i][vna_pkg::CR_W-1];
                    r_vm[i] <= ca[vna_pkg::MAG_W-1:0];
                end
            end else if (i_cmd.norm_step) begin
                if (|orv[61:34]) begin
                    r_vm[i] <= r_vm[i] >> 4;
                end else if (|orv[61:30]) begin
                    r_vm[i] <= r_vm[i] >> 1;
                end else if (~|orv[61:25]) begin
                    r_vm[i] <= r_vm[i] << 4;
                end else begin
                    r_vm[i] <= r_vm[i] << 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dvs <= vna_pkg::REM_W'(len) << 14;
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= (vna_pkg::REM_W'(r_vm[i][29:0]) << 14)
                          + vna_pkg::REM_W'(len[vna_pkg::LEN_W-1:1]);
                r_q[i]   <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_dvs <= r_dvs >> 1;
            for (int i = 0; i < 3; i++) begin
                if (r_rem[i] >= r_dvs) begin
                    r_rem[i] <= r_rem[i] - r_dvs;
                    r_q[i]   <= {r_q[i][vna_pkg::Q_W-2:0], 1'b1};
                end else begin
                    r_q[i]   <= {r_q[i][vna_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic signed [vna_pkg::NORM_W-1:0] qv;
        logic signed [vna_pkg::SUM_W-1:0]  s;
        logic signed [vna_pkg::SUM_W:0]    t;
        logic signed [vna_pkg::SUM_W:0]    st;
        for (int i = 0; i < 3; i++) begin
            qv     = $signed({1'b0, r_q[i]});
            nrm[i] = r_vn[i] ? -qv : qv;
            s  = $signed(r_sum_rd[(2-i)*vna_pkg::SUM_W +: vna_pkg::SUM_W]);
            t  = (vna_pkg::SUM_W+1)'(s) + (vna_pkg::SUM_W+1)'(nrm[i]);
            if (t > vna_pkg::SUM_MAX) begin
                st = vna_pkg::SUM_MAX;
            end else if (t < vna_pkg::SUM_MIN) begin
                st = vna_pkg::SUM_MIN;
            end else begin
                st = t;
            end
            sum_wdata[(2-i)*vna_pkg::SUM_W +: vna_pkg::SUM_W] = st[vna_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_queried_vertex <= r_vi;
            o_status         <= i_cmd.res_status;
            if (i_cmd.res_status == vna_pkg::ST_OK) begin
                o_normal_x <= nrm[0];
                o_normal_y <= nrm[1];
                o_normal_z <= nrm[2];
            end else begin
                o_normal_x <= '0;
                o_normal_y <= '0;
                o_normal_z <= '0;
            end
        end
    end

    always_comb begin
        o_stat.op       = vna_pkg::t_op'(r_op);
        o_stat.tri_ok   = vna_pkg::idx_ok(r_ca) && vna_pkg::idx_ok(r_cb)
                       && vna_pkg::idx_ok(r_cc);
        o_stat.vi_ok    = vna_pkg::idx_ok(r_vi);
        o_stat.clr_last = (32'(r_clr) == vna_pkg::VERTEX_COUNT - 1);
        o_stat.e_big    = |eor[vna_pkg::EDGE_W-1:30];
        o_stat.v_zero   = (orv == '0);
        o_stat.v_norm   = ~|orv[61:30] && orv[29];
    end

endmodule
